@@ rtl/core/pit_pkg.sv @@
package pit_pkg;

    // default widths of the timer value and the period counter
    localparam int unsigned VALUE_WIDTH = 20;
    localparam int unsigned COUNT_WIDTH = 12;

    // bus word and mode register layout
    localparam int unsigned READ_WIDTH    = 32;
    localparam int unsigned MODE_IV_WIDTH = 20;
    localparam int unsigned MODE_EN_BIT   = 24;
    localparam int unsigned MODE_IE_BIT   = 25;

    // stream widths
    localparam int unsigned S_TDATA_WIDTH = 24;
    localparam int unsigned S_TUSER_WIDTH = 3;
    localparam int unsigned M_TDATA_WIDTH = 40;

    // operation codes carried in s_tuser
    typedef enum logic [S_TUSER_WIDTH-1:0] {
        OP_TICK       = 3'd0,
        OP_WRITE_MODE = 3'd1,
        OP_READ_STAT  = 3'd2,
        OP_READ_ACK   = 3'd3,
        OP_READ_IMAGE = 3'd4,
        OP_READ_MODE  = 3'd5
    } op_t;

endpackage

@@ rtl/core/periodic_interval_timer_unit.sv @@
// channel | ports                   | contents
// --------+-------------------------+------------------------------------------
// input   | s_tvalid/s_tready       | s_tuser: operation; s_tdata: interval,
//         | s_tdata[23:0] s_tuser   |   enable, irq enable
// result  | m_tvalid/m_tready       | m_tdata: read_data, irq_line
//         | m_tdata[39:0]           |
//
// every word passes the input register, then the register update logic into the
// result register; a new word is taken each cycle while the result is not stalled
// the path from input register to result register is the timer compare and add
// reset (aresetn low, synchronous) clears the mode, counter and both stage valids
// a stalled result holds the input stage; s_tready follows m_tready through it
module periodic_interval_timer_unit #(
    parameter int unsigned VALUE_WIDTH = pit_pkg::VALUE_WIDTH,
    parameter int unsigned COUNT_WIDTH = pit_pkg::COUNT_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [19:0] new_interval, [20] new_enable, [21] new_irq_enable, zero pad
    input  logic [pit_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // [2:0] operation
    input  logic [pit_pkg::S_TUSER_WIDTH-1:0] s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] read_data, [32] irq_line, zero pad
    output logic [pit_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    localparam int unsigned IvWidth   = (VALUE_WIDTH < pit_pkg::MODE_IV_WIDTH) ?
                                        VALUE_WIDTH : pit_pkg::MODE_IV_WIDTH;
    localparam int unsigned WordWidth = VALUE_WIDTH + COUNT_WIDTH;
    localparam int unsigned WideWidth = 64;

    // input stage
    logic                               in_valid_reg;
    pit_pkg::op_t                       op_reg;
    logic [pit_pkg::MODE_IV_WIDTH-1:0]  new_iv_reg;
    logic                               new_en_reg;
    logic                               new_ie_reg;

    // timer state
    logic [VALUE_WIDTH-1:0]  interval_reg, interval_next;
    logic                    timer_en_reg, timer_en_next;
    logic                    irq_en_reg, irq_en_next;
    logic [VALUE_WIDTH-1:0]  value_reg, value_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    flag_reg, flag_next;
    logic                    counting_reg, counting_next;

    // result stage
    logic                              out_valid_reg;
    logic [pit_pkg::READ_WIDTH-1:0]    rdata_reg, rdata_next;
    logic                              irq_reg, irq_next;

    logic                              advance;
    logic                              wrap;
    logic [WordWidth-1:0]              value_word;
    logic [WideWidth-1:0]              value_wide;

    // handshake: the input stage moves whenever the result register is free
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pit_pkg::M_TDATA_WIDTH - pit_pkg::READ_WIDTH - 1){1'b0}},
                       irq_reg, rdata_reg};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            op_reg     <= pit_pkg::op_t'(s_tuser);
            new_iv_reg <= s_tdata[pit_pkg::MODE_IV_WIDTH-1:0];
            new_en_reg <= s_tdata[pit_pkg::MODE_IV_WIDTH];
            new_ie_reg <= s_tdata[pit_pkg::MODE_IV_WIDTH+1];
        end
    end

    // count and value word as seen by a value or image read
    assign value_word = {count_reg, value_reg};
    assign value_wide = WideWidth'(value_word);
    assign wrap       = (value_reg >= interval_reg);

    // register update and read mux for one word
    always_comb begin
        interval_next = interval_reg;
        timer_en_next = timer_en_reg;
        irq_en_next   = irq_en_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        flag_next     = flag_reg;
        counting_next = counting_reg;
        rdata_next    = '0;
        unique case (op_reg)
            pit_pkg::OP_TICK: begin
                if (counting_reg) begin
                    if (wrap) begin
                        value_next = '0;
                        count_next = count_reg + COUNT_WIDTH'(1);
                        flag_next  = 1'b1;
                        if (!timer_en_reg) begin
                            counting_next = 1'b0;
                        end
                    end else begin
                        value_next = value_reg + VALUE_WIDTH'(1);
                    end
                end
            end
            pit_pkg::OP_WRITE_MODE: begin
                interval_next = VALUE_WIDTH'(new_iv_reg[IvWidth-1:0]);
                timer_en_next = new_en_reg;
                irq_en_next   = new_ie_reg;
                if (new_en_reg) begin
                    counting_next = 1'b1;
                end
            end
            pit_pkg::OP_READ_STAT: begin
                rdata_next = pit_pkg::READ_WIDTH'(flag_reg);
            end
            pit_pkg::OP_READ_ACK: begin
                rdata_next = value_wide[pit_pkg::READ_WIDTH-1:0];
                flag_next  = 1'b0;
                count_next = '0;
            end
            pit_pkg::OP_READ_IMAGE: begin
                rdata_next = value_wide[pit_pkg::READ_WIDTH-1:0];
            end
            pit_pkg::OP_READ_MODE: begin
                rdata_next = pit_pkg::READ_WIDTH'(interval_reg);
                rdata_next[pit_pkg::MODE_EN_BIT] = timer_en_reg;
                rdata_next[pit_pkg::MODE_IE_BIT] = irq_en_reg;
            end
            default: begin
            end
        endcase
        irq_next = flag_next && irq_en_next;
    end

    // timer state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= '0;
            timer_en_reg  <= 1'b0;
            irq_en_reg    <= 1'b0;
            value_reg     <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            counting_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                interval_reg <= interval_next;
                timer_en_reg <= timer_en_next;
                irq_en_reg   <= irq_en_next;
                value_reg    <= value_next;
                count_reg    <= count_next;
                flag_reg     <= flag_next;
                counting_reg <= counting_next;
            end
        end
        if (advance && in_valid_reg) begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a stopped timer always rests at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        !counting_reg |-> (value_reg == '0))
        else $error("stopped timer holds a nonzero value");

    // an acknowledging read clears the flag and the period count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance && op_reg == pit_pkg::OP_READ_ACK)
        |=> (!flag_reg && count_reg == '0))
        else $error("value read did not clear flag and count");

    // a wrap with the enable clear stops the timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance && op_reg == pit_pkg::OP_TICK && counting_reg &&
         wrap && !timer_en_reg) |=> !counting_reg)
        else $error("timer kept counting after disabled wrap");

    // every processed word leaves a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("processed word produced no result");
`endif

endmodule

@@ verif/tb_periodic_interval_timer_unit.sv @@
`timescale 1ns / 100ps

module tb_periodic_interval_timer_unit;
    import pit_pkg::*;

    // operation codes the block leaves unused; they must read as zero and change nothing
    localparam logic [S_TUSER_WIDTH-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [S_TUSER_WIDTH-1:0] OP_SPARE_HI = 3'd7;

    localparam int unsigned RANDOM_WORDS = 700;
    localparam int unsigned MAX_WAIT     = 16;
    localparam int unsigned DRAIN_EVERY  = 150;
    localparam int unsigned MAX_PRINTED  = 50;

    // timer model and store of outstanding read words
    class timer_scoreboard;
        bit [VALUE_WIDTH-1:0] interval_r;
        bit                   enable_r;
        bit                   irq_enable_r;
        bit [VALUE_WIDTH-1:0] value_r;
        bit [COUNT_WIDTH-1:0] periods_r;
        bit                   flag_r;
        bit                   running_r;
        logic [READ_WIDTH-1:0] data_due[$];
        logic                  irq_due[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned wraps;
        int unsigned irq_seen;
        int unsigned acks;

        function int unsigned pending();
            return data_due.size();
        endfunction

        function logic [READ_WIDTH-1:0] image_word();
            return READ_WIDTH'({periods_r, value_r});
        endfunction

        // advance the model by one accepted input word and queue its result
        function void note_word(logic [S_TUSER_WIDTH-1:0] op, logic [MODE_IV_WIDTH-1:0] iv,
                                logic en, logic ie);
            logic [READ_WIDTH-1:0] data;
            data = '0;
            case (op)
                OP_TICK: begin
                    if (running_r) begin
                        if (value_r >= interval_r) begin
                            value_r   = '0;
                            periods_r = periods_r + 1'b1;
                            flag_r    = 1'b1;
                            wraps++;
                            // a cleared enable only takes effect at the wrap
                            if (!enable_r)
                                running_r = 1'b0;
                        end else begin
                            value_r = value_r + 1'b1;
                        end
                    end
                end
                OP_WRITE_MODE: begin
                    interval_r   = VALUE_WIDTH'(iv);
                    enable_r     = en;
                    irq_enable_r = ie;
                    if (en)
                        running_r = 1'b1;
                end
                OP_READ_STAT: begin
                    data = READ_WIDTH'(flag_r);
                end
                OP_READ_ACK: begin
                    // word carries the values from before the clear
                    data      = image_word();
                    flag_r    = 1'b0;
                    periods_r = '0;
                    acks++;
                end
                OP_READ_IMAGE: begin
                    data = image_word();
                end
                OP_READ_MODE: begin
                    data = READ_WIDTH'(interval_r)
                         | (READ_WIDTH'(enable_r) << MODE_EN_BIT)
                         | (READ_WIDTH'(irq_enable_r) << MODE_IE_BIT);
                end
                default: ;
            endcase
            data_due.push_back(data);
            irq_due.push_back(flag_r & irq_enable_r);
        endfunction

        // one line per mismatch, capped so a dead block does not flood the log
        task report_mismatch(string msg);
            if (errors < MAX_PRINTED)
                $display("%0t ns  mismatch: %s", $time, msg);
            errors++;
        endtask

        // compare an accepted result word against the oldest expectation
        task check_word(logic [M_TDATA_WIDTH-1:0] word);
            logic [READ_WIDTH-1:0] want_data;
            logic                  want_irq;
            checked++;
            if (word[READ_WIDTH] === 1'b1)
                irq_seen++;
            if (data_due.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing outstanding", word));
                return;
            end
            want_data = data_due.pop_front();
            want_irq  = irq_due.pop_front();
            if (word[READ_WIDTH-1:0] !== want_data || word[READ_WIDTH] !== want_irq)
                report_mismatch($sformatf("result %0d: read_data %h irq %b, want %h irq %b",
                                          checked, word[READ_WIDTH-1:0], word[READ_WIDTH],
                                          want_data, want_irq));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata  = '0;
    logic [S_TUSER_WIDTH-1:0] s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    timer_scoreboard sb = new();
    bit              steady;
    int unsigned     sent;

    periodic_interval_timer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard limit, far above the slowest legal run
    initial begin
        #1_000_000;
        $display("timeout with %0d words still outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // idle cycles before a word, none during steady stretches
    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [S_TUSER_WIDTH-1:0] pick_read();
        case ($urandom_range(0, 3))
            0:       return OP_READ_STAT;
            1:       return OP_READ_ACK;
            2:       return OP_READ_IMAGE;
            default: return OP_READ_MODE;
        endcase
    endfunction

    // offer one input word and hold it until taken; handshake sampled mid-cycle
    task automatic send_word(input logic [S_TUSER_WIDTH-1:0] op,
                             input logic [MODE_IV_WIDTH-1:0] iv,
                             input logic en, input logic ie);
        int unsigned gap;
        bit          taken;
        gap = draw_wait();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, ie, en, iv};
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            if (taken)
                sb.note_word(op, iv, en, ie);
            @(posedge aclk);
        end
        sent++;
    endtask

    task automatic tick_word();
        send_word(OP_TICK, MODE_IV_WIDTH'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
    endtask

    // result side stalls per word
    initial begin : result_sink
        int unsigned stall;
        bit          got;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            got = 1'b0;
            while (!got) begin
                @(negedge aclk);
                got = m_tvalid;
                @(posedge aclk);
            end
        end
    end

    // result monitor
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // stimulus
    initial begin : stimulus
        logic [MODE_IV_WIDTH-1:0] iv;
        int unsigned              run;
        int unsigned              since_drain;
        int unsigned              waited;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset state, stopped ticks and unused codes
        steady = 1'b1;
        send_word(OP_READ_MODE, '0, 1'b0, 1'b0);
        send_word(OP_READ_STAT, '0, 1'b0, 1'b0);
        tick_word();
        send_word(OP_READ_IMAGE, '0, 1'b0, 1'b0);
        send_word(OP_SPARE_LO, '1, 1'b1, 1'b1);
        send_word(OP_SPARE_HI, '1, 1'b1, 1'b1);
        // widest interval, all mode bits set
        send_word(OP_WRITE_MODE, '1, 1'b1, 1'b1);
        send_word(OP_READ_MODE, '0, 1'b0, 1'b0);
        repeat (3) tick_word();
        // interval lowered under the current value, next tick wraps
        send_word(OP_WRITE_MODE, 20'd2, 1'b1, 1'b1);
        tick_word();
        send_word(OP_READ_STAT, '0, 1'b0, 1'b0);
        send_word(OP_READ_IMAGE, '0, 1'b0, 1'b0);
        send_word(OP_READ_ACK, '0, 1'b0, 1'b0);
        send_word(OP_READ_IMAGE, '0, 1'b0, 1'b0);
        // zero interval wraps on every tick
        steady = 1'b0;
        send_word(OP_WRITE_MODE, '0, 1'b1, 1'b1);
        repeat (2) tick_word();
        send_word(OP_READ_ACK, '0, 1'b0, 1'b0);
        // enable cleared: keeps counting up to the wrap, then stops
        send_word(OP_WRITE_MODE, 20'd1, 1'b0, 1'b1);
        repeat (3) tick_word();
        send_word(OP_READ_ACK, '0, 1'b0, 1'b0);
        drain_results();

        // random: mostly programmed runs of ticks with reads mixed in, some noise
        since_drain = 0;
        while (sent < 27 + RANDOM_WORDS) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0) begin
                run = $urandom_range(1, 8);
                repeat (run)
                    send_word(S_TUSER_WIDTH'($urandom_range(0, 7)), MODE_IV_WIDTH'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 9))
                    0:       iv = '0;
                    1:       iv = MODE_IV_WIDTH'($urandom);
                    2:       iv = MODE_IV_WIDTH'('1 - $urandom_range(0, 3));
                    default: iv = MODE_IV_WIDTH'($urandom_range(1, 12));
                endcase
                send_word(OP_WRITE_MODE, iv, $urandom_range(0, 3) != 0,
                          1'($urandom_range(0, 1)));
                run = $urandom_range(1, 40);
                repeat (run) begin
                    case ($urandom_range(0, 19))
                        0:       send_word(OP_WRITE_MODE, MODE_IV_WIDTH'($urandom_range(0, 6)),
                                           1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1)));
                        1, 2, 3: send_word(pick_read(), MODE_IV_WIDTH'($urandom),
                                           1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1)));
                        default: tick_word();
                    endcase
                end
            end
            since_drain += run;
            if (since_drain >= DRAIN_EVERY) begin
                drain_results();
                since_drain = 0;
            end
        end

        // wind down: collect what is outstanding, then watch for strays
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 4000) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        repeat (10) @(posedge aclk);

        $display("run: %0d input words, %0d results checked", sent, sb.checked);
        $display("timer wrapped %0d times, %0d acknowledging reads, irq high on %0d results",
                 sb.wraps, sb.acks, sb.irq_seen);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pit_pkg.sv
rtl/core/periodic_interval_timer_unit.sv
verif/tb_periodic_interval_timer_unit.sv
